[rtl/kse_pkg.sv]
// Shared types, constants and the encoder step table for the key scan
// debounce / encoder block. No dependencies.
package kse_pkg;

  // Matrix geometry and field widths
  localparam int ROW_COUNT    = 5;
  localparam int COLUMN_COUNT = 7;
  localparam int DEBOUNCE_W   = 8;
  localparam int IDLE_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_LIMIT_RST     = DEBOUNCE_W'(5);
  localparam logic [IDLE_W-1:0]     KEY_IDLE_LIMIT_RST     = IDLE_W'(500);
  localparam logic [IDLE_W-1:0]     ENCODER_IDLE_LIMIT_RST = IDLE_W'(3000);
  localparam logic                  ENCODER_ENABLE_RST     = 1'b1;

  typedef logic [COLUMN_COUNT-1:0] row_t;
  typedef logic signed [1:0]       step_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_LIMIT     = 2'd0,
    REG_KEY_IDLE_LIMIT     = 2'd1,
    REG_ENCODER_IDLE_LIMIT = 2'd2,
    REG_ENCODER_ENABLE     = 2'd3
  } kse_reg_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_limit;
    logic [IDLE_W-1:0]     key_idle_limit;
    logic [IDLE_W-1:0]     encoder_idle_limit;
    logic                  encoder_enable;
  } kse_cfg_t;

  // One scan beat as held in the input register
  typedef struct packed {
    row_t [ROW_COUNT-1:0] rows;
    logic                 enc_b;
    logic                 enc_a;
  } kse_item_t;

  // Quadrature step from previous {B,A} and current {B,A}; a change on both
  // pins is invalid and decodes as no step.
  function automatic step_t step_lookup(input logic [1:0] prev, input logic [1:0] cur);
    step_t step;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: step = -2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: step = 2'sd1;
      default:                            step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

[rtl/kse_if.sv]
// Channel interfaces for the key scan block: scan beats in, reports out.
// Depends on nothing; widths match the fields of kse_pkg.
interface kse_scan_if;
  logic       valid;
  logic       ready;
  logic [6:0] row0_bits;
  logic [6:0] row1_bits;
  logic [6:0] row2_bits;
  logic [6:0] row3_bits;
  logic [6:0] row4_bits;
  logic       enc_a;
  logic       enc_b;

  modport source (output valid, row0_bits, row1_bits, row2_bits, row3_bits, row4_bits,
                  enc_a, enc_b, input ready);
  modport sink   (input valid, row0_bits, row1_bits, row2_bits, row3_bits, row4_bits,
                  enc_a, enc_b, output ready);
endinterface

interface kse_report_if;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [6:0]        out_row0;
  logic [6:0]        out_row1;
  logic [6:0]        out_row2;
  logic [6:0]        out_row3;
  logic [6:0]        out_row4;
  logic signed [1:0] step_delta;
  logic              sleep_request;

  modport source (output valid, send_valid, out_row0, out_row1, out_row2, out_row3,
                  out_row4, step_delta, sleep_request, input ready);
  modport sink   (input valid, send_valid, out_row0, out_row1, out_row2, out_row3,
                  out_row4, step_delta, sleep_request, output ready);
endinterface

[rtl/key_scan_debounce_encoder_idle_core.sv]
// Top level of the key scan debounce / encoder block: input register,
// config registers and the tick engine. Depends on kse_pkg, kse_if,
// kse_cfg_regs and kse_tick_engine.
//
//   channel   dir  handshake        payload
//   scan      in   valid / ready    row0_bits..row4_bits, enc_a, enc_b
//   report    out  valid / ready    send_valid, out_row0..4, step_delta, sleep_request
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// One report per scan beat, one beat per cycle sustained while the report
// is not stalled; a beat passes through the input register, then the
// engine's single pass of compares, table lookup and counter updates,
// into the report register, from which it leaves when report ready is high.
// Reset is synchronous and restores the register defaults and clears all
// tick state. A stalled report holds the engine; the input register still
// takes one more beat, so scan ready drops only when both stages are full.
module key_scan_debounce_encoder_idle_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kse_pkg::CFG_DATA_W-1:0]  cfg_data,
  kse_scan_if.sink                        scan,
  kse_report_if.source                    report
);
  import kse_pkg::*;

  kse_cfg_t  cfg;
  kse_item_t held;
  logic      held_valid;
  logic      take;

  kse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Take a beat when the input register is empty or moving on
  assign scan.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (scan.ready) begin
      held_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      held.rows[0] <= scan.row0_bits;
      held.rows[1] <= scan.row1_bits;
      held.rows[2] <= scan.row2_bits;
      held.rows[3] <= scan.row3_bits;
      held.rows[4] <= scan.row4_bits;
      held.enc_a   <= scan.enc_a;
      held.enc_b   <= scan.enc_b;
    end
  end

  kse_tick_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (held_valid),
    .item       (held),
    .take       (take),
    .report     (report)
  );

endmodule

[rtl/kse_cfg_regs.sv]
// Configuration register file for the key scan block.
// Depends on kse_pkg for the register indexes and the config struct.
module kse_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output kse_pkg::kse_cfg_t                cfg
);
  import kse_pkg::*;

  // Load the addressed register on a write, restore defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit     <= DEBOUNCE_LIMIT_RST;
      cfg.key_idle_limit     <= KEY_IDLE_LIMIT_RST;
      cfg.encoder_idle_limit <= ENCODER_IDLE_LIMIT_RST;
      cfg.encoder_enable     <= ENCODER_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (kse_reg_t'(cfg_index))
        REG_DEBOUNCE_LIMIT:     cfg.debounce_limit     <= cfg_data[DEBOUNCE_W-1:0];
        REG_KEY_IDLE_LIMIT:     cfg.key_idle_limit     <= cfg_data[IDLE_W-1:0];
        REG_ENCODER_IDLE_LIMIT: cfg.encoder_idle_limit <= cfg_data[IDLE_W-1:0];
        REG_ENCODER_ENABLE:     cfg.encoder_enable     <= cfg_data[0];
      endcase
    end
  end

endmodule

[rtl/kse_tick_engine.sv]
// Per-tick engine: step decode, idle counters, debounce and the report register.
// Depends on kse_pkg and kse_report_if.
module kse_tick_engine (
  input  logic               clk,
  input  logic               rst,
  input  kse_pkg::kse_cfg_t  cfg,
  input  logic               item_valid,
  input  kse_pkg::kse_item_t item,
  output logic               take,
  kse_report_if.source       report
);
  import kse_pkg::*;

  // Tick state
  logic [1:0]                  prev_pins;
  row_t [ROW_COUNT-1:0]        snapshot;
  logic [DEBOUNCE_W-1:0]       stable_count;
  logic [IDLE_W-1:0]           key_idle_count;
  logic [IDLE_W-1:0]           turn_idle_count;

  // Report register
  logic                        res_valid;
  logic                        res_send;
  row_t [ROW_COUNT-1:0]        res_rows;
  step_t                       res_step;
  logic                        res_sleep;

  // Next values
  logic [1:0]                  pins;
  step_t                       step;
  logic                        empty;
  logic                        same;
  logic [IDLE_W-1:0]           key_bump;
  logic [IDLE_W-1:0]           turn_bump;
  logic                        sleep_hit;
  logic [IDLE_W-1:0]           key_idle_count_next;
  logic [IDLE_W-1:0]           turn_idle_count_next;
  logic [DEBOUNCE_W-1:0]       stable_bump;
  logic [DEBOUNCE_W-1:0]       stable_count_next;
  row_t [ROW_COUNT-1:0]        snapshot_next;
  logic                        send;

  // Advance the held beat when the report slot is free or being drained
  assign take = item_valid && (!res_valid || report.ready);

  // Decode the encoder step and compare the snapshot
  always_comb begin
    pins  = {item.enc_b, item.enc_a};
    step  = step_lookup(prev_pins, pins);
    empty = (item.rows == '0);
    same  = (item.rows == snapshot);
  end

  // Idle counters: saturate, clear on activity, clear both on sleep
  always_comb begin
    key_bump  = empty ? ((key_idle_count == '1) ? key_idle_count : key_idle_count + 1'b1)
                      : '0;
    turn_bump = (step == 2'sd0)
              ? ((turn_idle_count == '1) ? turn_idle_count : turn_idle_count + 1'b1)
              : '0;
    sleep_hit = (key_bump > cfg.key_idle_limit) &&
                (!cfg.encoder_enable || (turn_bump > cfg.encoder_idle_limit));
    key_idle_count_next  = sleep_hit ? '0 : key_bump;
    turn_idle_count_next = sleep_hit ? '0 : turn_bump;
  end

  // Debounce: a step sends at once, a stable snapshot sends at the limit
  always_comb begin
    stable_bump       = (stable_count == '1) ? stable_count : stable_count + 1'b1;
    stable_count_next = stable_count;
    snapshot_next     = snapshot;
    send              = 1'b0;
    if (step != 2'sd0) begin
      send = 1'b1;
    end else if (same) begin
      if (stable_bump == cfg.debounce_limit) begin
        send              = 1'b1;
        stable_count_next = '0;
      end else begin
        stable_count_next = stable_bump;
      end
    end else begin
      stable_count_next = '0;
      snapshot_next     = item.rows;
    end
  end

  // Hold state and report valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins       <= '0;
      snapshot        <= '0;
      stable_count    <= '0;
      key_idle_count  <= '0;
      turn_idle_count <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (take) begin
        prev_pins       <= pins;
        snapshot        <= snapshot_next;
        stable_count    <= stable_count_next;
        key_idle_count  <= key_idle_count_next;
        turn_idle_count <= turn_idle_count_next;
        res_valid       <= 1'b1;
      end else if (report.ready) begin
        res_valid       <= 1'b0;
      end
    end
  end

  // Load the report payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_send  <= send;
      res_rows  <= snapshot_next;
      res_step  <= step;
      res_sleep <= sleep_hit;
    end
  end

  assign report.valid         = res_valid;
  assign report.send_valid    = res_send;
  assign report.out_row0      = res_rows[0];
  assign report.out_row1      = res_rows[1];
  assign report.out_row2      = res_rows[2];
  assign report.out_row3      = res_rows[3];
  assign report.out_row4      = res_rows[4];
  assign report.step_delta    = res_step;
  assign report.sleep_request = res_sleep;

endmodule

[rtl/kse_checker.sv]
// Port-level checks for the key scan block, bound to its top level.
// Depends only on the top level's ports.
module kse_checker (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic              send_valid,
  input logic signed [1:0] step_delta
);

  // A report never appears in the cycle after reset
  assert property (@(posedge clk) rst |=> !valid)
    else $error("report valid right after reset");

  // Any decoded step sends a packet
  assert property (@(posedge clk) disable iff (rst)
                   (valid && step_delta != 2'sd0) |-> send_valid)
    else $error("step without packet");

  // The step is only ever -1, 0 or +1
  assert property (@(posedge clk) disable iff (rst)
                   valid |-> (step_delta != -2'sd2))
    else $error("step out of range");

  // A stalled report stays offered
  assert property (@(posedge clk) disable iff (rst)
                   (valid && !ready) |=> valid)
    else $error("report dropped while stalled");

endmodule

bind key_scan_debounce_encoder_idle_core kse_checker u_kse_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (report.valid),
  .ready      (report.ready),
  .send_valid (report.send_valid),
  .step_delta (report.step_delta)
);

[sim/key_scan_debounce_encoder_idle_core_tb.sv]
// Self-checking testbench for key_scan_debounce_encoder_idle_core: a directed table, then
// random scan traffic over several register settings, checked beat by beat.
// Depends on kse_pkg, kse_scan_if / kse_report_if and the core RTL.
`timescale 1ns / 1ps

module key_scan_debounce_encoder_idle_core_tb;
  import kse_pkg::*;

  localparam int RAND_PER_PHASE = 279;
  localparam int PHASES         = 7;
  localparam int STALL_CYCLES   = 40;
  localparam int MAX_SHOWN      = 10;

  typedef struct packed {
    logic                 send;
    row_t [ROW_COUNT-1:0] rows;
    step_t                step;
    logic                 sleep;
  } report_t;

  typedef struct {
    kse_item_t beat;
    bit        typed;
    report_t   want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  kse_scan_if   scan_bus ();
  kse_report_if report_bus ();

  key_scan_debounce_encoder_idle_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_bus),
    .report    (report_bus)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block's registers and tick state
  logic [DEBOUNCE_W-1:0] lim_debounce = DEBOUNCE_LIMIT_RST;
  logic [IDLE_W-1:0]     lim_key_idle = KEY_IDLE_LIMIT_RST;
  logic [IDLE_W-1:0]     lim_enc_idle = ENCODER_IDLE_LIMIT_RST;
  logic                  enc_on       = ENCODER_ENABLE_RST;

  logic [1:0]            last_pins    = '0;
  row_t [ROW_COUNT-1:0]  held_rows    = '0;
  logic [DEBOUNCE_W-1:0] stable_ticks = '0;
  logic [IDLE_W-1:0]     key_idle     = '0;
  logic [IDLE_W-1:0]     turn_idle    = '0;

  report_t awaited_reports [$];

  int snd_pct = 0;
  int rcv_pct = 0;
  bit stall_request = 1'b0;

  int n_beats   = 0;
  int n_reports = 0;
  int n_packets = 0;
  int n_sleeps  = 0;
  int n_errors  = 0;

  int unsigned phase_debounce [PHASES] = '{1, 255, 3, 6, 2, 0, 4};
  int unsigned phase_key_idle [PHASES] = '{0, 65534, 12, 40, 0, 0, 20};
  int unsigned phase_enc_idle [PHASES] = '{0, 65534, 25, 5, 65534, 0, 10};
  int unsigned phase_enc_on   [PHASES] = '{0, 1, 1, 0, 1, 0, 1};

  // Quadrature step: map {B,A} to its Gray position, a move of one place either way
  // is a step, two places means both pins changed and counts as no step.
  function automatic step_t quad_step(input logic [1:0] was, input logic [1:0] now);
    logic [1:0] p0;
    logic [1:0] p1;
    logic [1:0] turn;
    p0   = {was[1], was[1] ^ was[0]};
    p1   = {now[1], now[1] ^ now[0]};
    turn = p1 - p0;
    case (turn)
      2'd1:    return -2'sd1;
      2'd3:    return 2'sd1;
      default: return 2'sd0;
    endcase
  endfunction

  // Advance the mirrored state by one scan beat and return the report it causes
  function automatic report_t next_report(input kse_item_t beat);
    report_t    r;
    logic [1:0] pins;
    step_t      st;
    logic       empty;
    logic       same;
    pins      = {beat.enc_b, beat.enc_a};
    st        = quad_step(last_pins, pins);
    last_pins = pins;
    empty     = (beat.rows == '0);
    same      = (beat.rows == held_rows);

    // idle counters saturate, a sleep request clears both
    if (empty) begin
      if (key_idle != '1) key_idle = key_idle + 1'b1;
    end else begin
      key_idle = '0;
    end
    if (st == 2'sd0) begin
      if (turn_idle != '1) turn_idle = turn_idle + 1'b1;
    end else begin
      turn_idle = '0;
    end
    r.sleep = 1'b0;
    if (key_idle > lim_key_idle && (!enc_on || turn_idle > lim_enc_idle)) begin
      r.sleep   = 1'b1;
      key_idle  = '0;
      turn_idle = '0;
    end

    // a step sends at once; otherwise debounce the snapshot
    r.send = 1'b0;
    if (st != 2'sd0) begin
      r.send = 1'b1;
    end else if (same) begin
      if (stable_ticks != '1) stable_ticks = stable_ticks + 1'b1;
      if (stable_ticks == lim_debounce) begin
        r.send       = 1'b1;
        stable_ticks = '0;
      end
    end else begin
      stable_ticks = '0;
      held_rows    = beat.rows;
    end
    r.rows = held_rows;
    r.step = st;
    return r;
  endfunction

  function automatic kse_item_t beat_of(input row_t r0, input row_t r1, input row_t r2,
                                        input row_t r3, input row_t r4,
                                        input logic a, input logic b);
    kse_item_t it;
    it.rows[0] = r0;
    it.rows[1] = r1;
    it.rows[2] = r2;
    it.rows[3] = r3;
    it.rows[4] = r4;
    it.enc_a   = a;
    it.enc_b   = b;
    return it;
  endfunction

  function automatic report_t pkt(input logic send, input row_t fill, input step_t st,
                                  input logic sl);
    report_t r;
    r.send  = send;
    r.rows  = {ROW_COUNT{fill}};
    r.step  = st;
    r.sleep = sl;
    return r;
  endfunction

  // Offer one beat, hold it until taken, then queue what it should produce
  task automatic offer_beat(input kse_item_t b, input bit typed, input report_t want);
    report_t predicted;
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      scan_bus.valid <= 1'b0;
      @(negedge clk);
    end
    scan_bus.valid     <= 1'b1;
    scan_bus.row0_bits <= b.rows[0];
    scan_bus.row1_bits <= b.rows[1];
    scan_bus.row2_bits <= b.rows[2];
    scan_bus.row3_bits <= b.rows[3];
    scan_bus.row4_bits <= b.rows[4];
    scan_bus.enc_a     <= b.enc_a;
    scan_bus.enc_b     <= b.enc_b;
    do @(posedge clk); while (!scan_bus.ready);
    predicted = next_report(b);
    awaited_reports.push_back(typed ? want : predicted);
    n_beats++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued report has come back
  task automatic drain;
    scan_bus.valid <= 1'b0;
    do @(negedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic put_reg(input kse_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input int unsigned deb, input int unsigned kidle,
                               input int unsigned eidle, input int unsigned en);
    put_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_W'(deb));
    put_reg(REG_KEY_IDLE_LIMIT, CFG_DATA_W'(kidle));
    put_reg(REG_ENCODER_IDLE_LIMIT, CFG_DATA_W'(eidle));
    put_reg(REG_ENCODER_ENABLE, CFG_DATA_W'(en));
    cfg_we <= 1'b0;
    @(negedge clk);
    lim_debounce = DEBOUNCE_W'(deb);
    lim_key_idle = IDLE_W'(kidle);
    lim_enc_idle = IDLE_W'(eidle);
    enc_on       = en[0];
  endtask

  // Compare one taken report with the oldest expectation
  task automatic check_report;
    report_t got;
    report_t want;
    got.send    = report_bus.send_valid;
    got.rows[0] = report_bus.out_row0;
    got.rows[1] = report_bus.out_row1;
    got.rows[2] = report_bus.out_row2;
    got.rows[3] = report_bus.out_row3;
    got.rows[4] = report_bus.out_row4;
    got.step    = report_bus.step_delta;
    got.sleep   = report_bus.sleep_request;
    if (awaited_reports.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_SHOWN)
        $display("unexpected report beat: send=%0b rows=%h step=%0d sleep=%0b",
                 got.send, got.rows, got.step, got.sleep);
    end else begin
      want = awaited_reports.pop_front();
      n_reports++;
      if (want.send)  n_packets++;
      if (want.sleep) n_sleeps++;
      if (got.send !== want.send || got.rows !== want.rows ||
          got.step !== want.step || got.sleep !== want.sleep) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
          $display("report %0d mismatch: expected send=%0b rows=%h step=%0d sleep=%0b",
                   n_reports, want.send, want.rows, want.step, want.sleep);
          $display("report %0d mismatch:   actual send=%0b rows=%h step=%0d sleep=%0b",
                   n_reports, got.send, got.rows, got.step, got.sleep);
        end
      end
    end
  endtask

  // Sample taken report beats
  always @(posedge clk) begin
    if (!rst && report_bus.valid && report_bus.ready) check_report();
  end

  // Report ready: random back-pressure, or a long counted hold-off on request
  initial begin
    int stall_left;
    stall_left       = 0;
    report_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        report_bus.ready <= 1'b0;
      end else begin
        report_bus.ready <= !(rcv_pct != 0 && $urandom_range(99) < rcv_pct);
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t              dir_tab [21];
    kse_item_t             b;
    report_t               none;
    row_t [ROW_COUNT-1:0]  scene_rows;
    logic [63:0]           wide;
    logic [1:0]            enc_pos;
    bit                    spin;
    bit                    cw;
    int                    hold_left;
    int                    pick;
    int                    idx;
    int unsigned           deb;
    int unsigned           kidle;
    int unsigned           eidle;
    int unsigned           en;

    scan_bus.valid     = 1'b0;
    scan_bus.row0_bits = '0;
    scan_bus.row1_bits = '0;
    scan_bus.row2_bits = '0;
    scan_bus.row3_bits = '0;
    scan_bus.row4_bits = '0;
    scan_bus.enc_a     = 1'b0;
    scan_bus.enc_b     = 1'b0;
    none       = '0;
    scene_rows = '0;
    enc_pos    = '0;
    spin       = 1'b0;
    cw         = 1'b0;
    hold_left  = 0;
    idx        = 0;

    // Directed table; typed rows assume the reset settings (debounce of 5)
    dir_tab[0]  = '{beat_of('0, '0, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                    pkt(1'b0, 7'h00, 2'sd0, 1'b0)};
    dir_tab[1]  = '{beat_of('0, '0, '0, '0, '0, 1'b1, 1'b0), 1'b1,
                    pkt(1'b1, 7'h00, -2'sd1, 1'b0)};
    // both pins change: no step
    dir_tab[2]  = '{beat_of('0, '0, '0, '0, '0, 1'b0, 1'b1), 1'b1,
                    pkt(1'b0, 7'h00, 2'sd0, 1'b0)};
    dir_tab[3]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b1,
                    pkt(1'b0, 7'h7f, 2'sd0, 1'b0)};
    dir_tab[4]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b0, none};
    dir_tab[5]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b0, none};
    dir_tab[6]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b0, none};
    dir_tab[7]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b0, none};
    // held long enough: debounced send
    dir_tab[8]  = '{beat_of('1, '1, '1, '1, '1, 1'b0, 1'b1), 1'b1,
                    pkt(1'b1, 7'h7f, 2'sd0, 1'b0)};
    // a step sends the stored snapshot, not the new one
    dir_tab[9]  = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b1, 1'b1), 1'b1,
                    pkt(1'b1, 7'h7f, 2'sd1, 1'b0)};
    dir_tab[10] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b1, 1'b0), 1'b0, none};
    dir_tab[11] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b0, 1'b0), 1'b0, none};
    dir_tab[12] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b0, 1'b0), 1'b0, none};
    dir_tab[13] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b1, 1'b0), 1'b0, none};
    dir_tab[14] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b0, 1'b0), 1'b0, none};
    dir_tab[15] = '{beat_of(7'h55, 7'h2a, 7'h01, 7'h40, 7'h00, 1'b1, 1'b1), 1'b0, none};
    dir_tab[16] = '{beat_of(7'h00, 7'h00, 7'h00, 7'h00, 7'h7f, 1'b1, 1'b1), 1'b0, none};
    dir_tab[17] = '{beat_of(7'h7f, 7'h00, 7'h00, 7'h00, 7'h00, 1'b1, 1'b1), 1'b0, none};
    dir_tab[18] = '{beat_of(7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 1'b0, 1'b1), 1'b0, none};
    dir_tab[19] = '{beat_of(7'h40, 7'h20, 7'h10, 7'h08, 7'h04, 1'b0, 1'b1), 1'b0, none};
    dir_tab[20] = '{beat_of('0, '0, '0, '0, '0, 1'b0, 1'b0), 1'b0, none};

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table with no idling
    foreach (dir_tab[i]) offer_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    enc_pos = 2'd0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      deb   = phase_debounce[ph];
      kidle = phase_key_idle[ph];
      eidle = phase_enc_idle[ph];
      en    = phase_enc_on[ph];
      if (deb == 0) begin
        deb   = $urandom_range(1, 16);
        kidle = $urandom_range(0, 60);
        eidle = $urandom_range(0, 60);
        en    = $urandom_range(1);
      end
      load_settings(deb, kidle, eidle, en);

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // idling profile: sender light / receiver heavy, then swapped, then none
        if (idx < 650) begin
          snd_pct = 11;
          rcv_pct = 54;
        end else if (idx < 1300) begin
          snd_pct = 54;
          rcv_pct = 11;
        end else begin
          snd_pct = 0;
          rcv_pct = 0;
        end
        if (idx == 100 || idx == 1500) stall_request = 1'b1;
        if (idx == 800) drain();

        // new scene: key pattern, how long it is held, encoder activity
        if (hold_left == 0) begin
          pick       = $urandom_range(99);
          scene_rows = '0;
          if (pick < 40) begin
            scene_rows = '0;
          end else if (pick < 75) begin
            scene_rows[$urandom_range(ROW_COUNT - 1)][$urandom_range(COLUMN_COUNT - 1)] = 1'b1;
            if ($urandom_range(1))
              scene_rows[$urandom_range(ROW_COUNT - 1)][$urandom_range(COLUMN_COUNT - 1)] = 1'b1;
          end else if (pick < 92) begin
            wide       = {$urandom(), $urandom()};
            scene_rows = wide[ROW_COUNT*COLUMN_COUNT-1:0];
          end else begin
            scene_rows = '1;
          end
          if (scene_rows == '0 && $urandom_range(1))
            hold_left = $urandom_range(1, 80);
          else if ($urandom_range(9) < 7)
            hold_left = $urandom_range(1, lim_debounce + 3);
          else
            hold_left = $urandom_range(1, 4);
          spin = ($urandom_range(9) < 3);
          cw   = 1'($urandom_range(1));
        end
        hold_left--;

        // encoder: walk in one direction while spinning, rare jitter otherwise
        if (spin) begin
          pick = $urandom_range(9);
          if (pick < 7)       enc_pos = enc_pos + (cw ? 2'd1 : 2'd3);
          else if (pick == 7) enc_pos = enc_pos + 2'd2;
        end else if ($urandom_range(99) < 3) begin
          enc_pos = 2'($urandom_range(3));
        end

        b.rows = scene_rows;
        // noise beat: random rows and pins, scene untouched
        if ($urandom_range(99) < 8) begin
          wide    = {$urandom(), $urandom()};
          b.rows  = wide[ROW_COUNT*COLUMN_COUNT-1:0];
          enc_pos = 2'($urandom_range(3));
        end
        b.enc_b = enc_pos[1];
        b.enc_a = enc_pos[1] ^ enc_pos[0];
        offer_beat(b, 1'b0, none);
        idx++;
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d scan beats over %0d register settings plus reset defaults",
             n_beats, PHASES);
    $display("checked %0d reports: %0d packets, %0d sleep requests, %0d mismatches",
             n_reports, n_packets, n_sleeps, n_errors);
    if (n_errors == 0 && awaited_reports.size() == 0) begin
      $display("key_scan_debounce_encoder_idle_core_tb: done, clean");
    end else begin
      $display("key_scan_debounce_encoder_idle_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("key_scan_debounce_encoder_idle_core_tb: done, errors");
    $finish;
  end

endmodule
